>>> hdl/nfc_response_frame_receiver_assert.svh
// assertion macros for the nfc response frame receiver
// depends on a clock named clk and an active-low reset named arst_n in the using module
`ifndef NFC_RESPONSE_FRAME_RECEIVER_ASSERT_SVH
`define NFC_RESPONSE_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define NFC_RX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define NFC_RX_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define NFC_RX_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define NFC_RX_ASSERT(lbl, prop, msg)
`define NFC_RX_ASSERT_IMPL(lbl, pre, post, msg)
`define NFC_RX_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hdl/nfc_rx_pkg.sv
// shared types, codes and the start-code search step for the frame receiver
// no dependencies
`timescale 1ns / 1ps
package nfc_rx_pkg;

	// scan phases
	localparam logic [2:0] PH_NONE = 3'd0;
	localparam logic [2:0] PH_ONE  = 3'd1;
	localparam logic [2:0] PH_TWO  = 3'd2;
	localparam logic [2:0] PH_HEAD = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// byte values of the frame format
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [7:0] BYTE_RESP = 8'hD7;

	// positions within a frame
	localparam logic [16:0] POS_HDR3    = 17'd3;
	localparam logic [16:0] POS_HDR4    = 17'd4;
	localparam logic [16:0] POS_LEN_HI  = 17'd6;
	localparam logic [16:0] POS_CODE    = 17'd8;
	localparam logic [16:0] POS_CMD     = 17'd9;
	localparam logic [16:0] POS_DATA    = 17'd10;
	localparam logic [16:0] OFS_DATA_END = 17'd7;
	localparam logic [16:0] OFS_FINAL   = 17'd9;
	localparam logic [15:0] MIN_PAYLOAD = 16'd2;

	// result queue geometry
	localparam int unsigned FIFO_AW = 2;
	localparam logic [FIFO_AW:0] FIFO_DEPTH = (FIFO_AW+1)'(1 << FIFO_AW);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} result_t;

	// one byte of the start-code search
	function automatic logic [2:0] hunt_step(input logic [2:0] ph, input logic [7:0] b);
		logic [2:0] nx;
		case (ph)
			PH_TWO: begin
				if (b == BYTE_FF) nx = PH_HEAD;
				else if (b == BYTE_ZERO) nx = PH_TWO;
				else nx = PH_NONE;
			end
			PH_ONE: begin
				nx = (b == BYTE_ZERO) ? PH_TWO : PH_NONE;
			end
			default: begin
				nx = (b == BYTE_ZERO) ? PH_ONE : PH_NONE;
			end
		endcase
		return nx;
	endfunction

endpackage

>>> hdl/nfc_rx_scan.sv
// front part: byte scanner that finds frames, checks the response header and
// classifies each received byte; depends on nfc_rx_pkg and the assertion header
`timescale 1ns / 1ps
`include "nfc_response_frame_receiver_assert.svh"
module nfc_rx_scan import nfc_rx_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  logic          cfg_wr,
	input  logic [7:0]    cfg_data,
	output logic          res_valid,
	output result_t       res
);

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  win0_q, win0_d;
	logic [7:0]  win1_q, win1_d;
	logic [16:0] pos_q, pos_d;
	logic [15:0] len_q, len_d;
	logic        match_q, match_d;
	logic [7:0]  cmd_q;
	logic [2:0]  h1, h2, h3;
	logic [16:0] final_pos, data_end;

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= 8'd0;
		end else if (cfg_wr) begin
			cmd_q <= cfg_data;
		end
	end

	// replay of a rejected header through the start-code search
	always_comb begin
		h1 = hunt_step(PH_NONE, win0_q);
		h2 = hunt_step(h1, win1_q);
		h3 = hunt_step(h2, rx_byte);
	end

	// frame bounds from the length field
	assign final_pos = {1'b0, len_q} + OFS_FINAL;
	assign data_end  = {1'b0, len_q} + OFS_DATA_END;

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		win0_d    = win0_q;
		win1_d    = win1_q;
		pos_d     = pos_q;
		len_d     = len_q;
		match_d   = match_q;
		res_valid = 1'b0;
		res.kind  = KIND_ACK;
		res.data  = 8'd0;
		if (accept) begin
			case (phase_q)
				PH_HEAD: begin
					if (pos_q == POS_HDR3) begin
						win0_d = rx_byte;
						pos_d  = POS_HDR4;
					end else if (pos_q == POS_HDR4) begin
						win1_d = rx_byte;
						pos_d  = pos_q + 17'd1;
					end else if (win0_q == BYTE_ZERO && win1_q == BYTE_FF
							&& rx_byte == BYTE_ZERO) begin
						// acknowledge frame
						phase_d   = PH_NONE;
						pos_d     = 17'd0;
						res_valid = 1'b1;
						res.kind  = KIND_ACK;
					end else if (win0_q == BYTE_FF && win1_q == BYTE_FF) begin
						// extended frame, low length byte
						phase_d = PH_BODY;
						len_d   = {8'd0, rx_byte};
						match_d = 1'b0;
						pos_d   = POS_LEN_HI;
					end else begin
						phase_d = h3;
						pos_d   = (h3 == PH_HEAD) ? POS_HDR3 : 17'd0;
					end
				end
				PH_BODY: begin
					if (pos_q == POS_LEN_HI) begin
						len_d[15:8] = rx_byte;
					end else if (pos_q == POS_CODE) begin
						match_d = (len_q >= MIN_PAYLOAD) && (rx_byte == BYTE_RESP);
					end else if (pos_q == POS_CMD) begin
						if ({1'b0, rx_byte} != ({1'b0, cmd_q} + 9'd1)) begin
							match_d = 1'b0;
						end
					end
					// payload data after the two header bytes
					if (pos_q >= POS_DATA && pos_q <= data_end && match_q) begin
						res_valid = 1'b1;
						res.kind  = KIND_DATA;
						res.data  = rx_byte;
					end
					// final byte of the frame
					if (pos_q >= POS_CMD && pos_q == final_pos) begin
						if (match_d) begin
							res_valid = 1'b1;
							res.kind  = KIND_END;
						end
						phase_d = PH_NONE;
						pos_d   = 17'd0;
						len_d   = 16'd0;
						match_d = 1'b0;
					end else begin
						pos_d = pos_q + 17'd1;
					end
				end
				default: begin
					phase_d = hunt_step(phase_q, rx_byte);
					if (phase_d == PH_HEAD) begin
						pos_d = POS_HDR3;
					end
				end
			endcase
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			pos_q   <= 17'd0;
			len_q   <= 16'd0;
			match_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			match_q <= match_d;
		end
	end

	// header bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= 8'd0;
			win1_q <= 8'd0;
		end else begin
			win0_q <= win0_d;
			win1_q <= win1_d;
		end
	end

	`NFC_RX_ASSERT_IMPL(a_body_pos, phase_q == PH_BODY, pos_q >= POS_LEN_HI,
		"body position below length field")
	`NFC_RX_ASSERT_IMPL(a_ack_in_head, res_valid && res.kind == KIND_ACK, phase_q == PH_HEAD,
		"acknowledge outside header")
	`NFC_RX_ASSERT_IMPL(a_data_matched, res_valid && res.kind == KIND_DATA,
		match_q && len_q >= MIN_PAYLOAD, "data from unmatched payload")

endmodule

>>> hdl/nfc_rx_fifo.sv
// short result queue between the scanner and the output stage
// depends on nfc_rx_pkg and the assertion header
`timescale 1ns / 1ps
`include "nfc_response_frame_receiver_assert.svh"
module nfc_rx_fifo import nfc_rx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    full,
	input  logic    rd_en,
	output result_t rd_data,
	output logic    nonempty
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 do_wr, do_rd;

	assign full     = (count_q == FIFO_DEPTH);
	assign nonempty = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && nonempty;
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	`NFC_RX_ASSERT(a_count_range, count_q <= FIFO_DEPTH, "queue count above depth")
	`NFC_RX_ASSERT_NEXT(a_count_up, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "queue count missed a write")

endmodule

>>> hdl/nfc_rx_emit.sv
// back part: output register that takes queued results and presents them
// to the consumer with their field formatting; depends on nfc_rx_pkg
`timescale 1ns / 1ps
module nfc_rx_emit import nfc_rx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  result_t    q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic       last
);

	logic    out_valid_q;
	result_t out_q;

	// refill when the held result leaves or none is held
	assign q_pop = q_nonempty && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_data;
		end
	end

	// result fields
	assign empty       = !out_valid_q;
	assign result_kind = out_q.kind;
	assign data_byte   = (out_q.kind == KIND_DATA) ? out_q.data : 8'd0;
	assign last        = (out_q.kind == KIND_END);

endmodule

>>> hdl/nfc_response_frame_receiver.sv
// Response frame receiver: takes one received byte per cycle on push/full, finds
// frames behind the start code 00 00 FF, reports acknowledge frames, and for an
// extended frame whose payload opens with D7 and the expected command plus one
// delivers the remaining payload bytes and an end marker on empty/pop. Each byte
// is scanned in the cycle it is accepted, so a new byte can be taken every cycle
// while full is low; its result enters the queue at the edge that accepts the byte. The
// four-entry result queue behind the one-result output register sets the only
// stall: full is high while the queue holds four results, whether or not the
// consumer pops in that cycle, and a pop frees an entry from the next cycle on.
// cfg_ready is always high; write the command register only while no frame is
// in flight.
`timescale 1ns / 1ps
module nfc_response_frame_receiver import nfc_rx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] result_kind,
	output logic [7:0] data_byte,
	output logic       last
);

	logic    accept;
	logic    res_valid;
	result_t res;
	logic    q_pop;
	logic    q_nonempty;
	result_t q_data;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// front: scanner and classifier
	nfc_rx_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg_wr    (cfg_valid),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	// queue between the two parts
	nfc_rx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.full     (full),
		.rd_en    (q_pop),
		.rd_data  (q_data),
		.nonempty (q_nonempty)
	);

	// back: output register
	nfc_rx_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.result_kind (result_kind),
		.data_byte   (data_byte),
		.last        (last)
	);

endmodule

>>> tb/tb.sv
// testbench for nfc_response_frame_receiver: byte stream in, result queue out
// self-checking against an in-bench frame scanner; depends on nfc_rx_pkg and the rtl top
`timescale 1ns / 1ps
module tb;
	import nfc_rx_pkg::*;

	localparam int HOLD_CYCLES = 4;

	typedef enum logic [1:0] {REQ_BYTE, REQ_CFG, REQ_DRAIN, REQ_MODE} req_kind_t;

	typedef struct {
		req_kind_t  kind;
		logic [7:0] value;
		int         send_idle;
		int         recv_stall;
	} link_request_t;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} frame_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       cfg_ready;
	logic       empty;
	logic [1:0] result_kind;
	logic [7:0] data_byte;
	logic       last;

	link_request_t link_requests[$];
	frame_result_t awaited_results[$];
	int            mismatches = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            quiet_cycles = 0;
	int            bytes_queued = 0;
	logic [7:0]    cmd_plan = 8'h00;

	// scanner state
	logic [2:0]  scan_ph = PH_NONE;
	logic [7:0]  hdr_b3 = 8'h00;
	logic [7:0]  hdr_b4 = 8'h00;
	logic [16:0] frame_pos = '0;
	logic [15:0] pay_len = '0;
	logic        resp_ok = 1'b0;
	logic [7:0]  cmd_reg = 8'h00;

	nfc_response_frame_receiver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.empty      (empty),
		.pop        (pop),
		.result_kind(result_kind),
		.data_byte  (data_byte),
		.last       (last)
	);

	initial forever #5 clk = ~clk;

	// one byte of the start-code search
	function automatic void search_start(input logic [7:0] b);
		if (scan_ph == PH_TWO) begin
			if (b == BYTE_FF) begin
				scan_ph = PH_HEAD;
				frame_pos = POS_HDR3;
			end else if (b != BYTE_ZERO) begin
				scan_ph = PH_NONE;
			end
		end else if (scan_ph == PH_ONE) begin
			scan_ph = (b == BYTE_ZERO) ? PH_TWO : PH_NONE;
		end else begin
			scan_ph = (b == BYTE_ZERO) ? PH_ONE : PH_NONE;
		end
	endfunction

	// advance the scanner by one accepted byte, returns 1 when a result is due
	function automatic bit scan_byte(input logic [7:0] b, output frame_result_t res);
		logic [16:0] final_pos;
		logic [7:0]  h3;
		logic [7:0]  h4;
		bit          got;
		got = 1'b0;
		res.kind = KIND_ACK;
		res.data = 8'h00;
		res.last = 1'b0;
		if (scan_ph == PH_HEAD) begin
			if (frame_pos == POS_HDR3) begin
				hdr_b3 = b;
				frame_pos = POS_HDR4;
			end else if (frame_pos == POS_HDR4) begin
				hdr_b4 = b;
				frame_pos = POS_HDR4 + 17'd1;
			end else if (hdr_b3 == BYTE_ZERO && hdr_b4 == BYTE_FF && b == BYTE_ZERO) begin
				scan_ph = PH_NONE;
				frame_pos = '0;
				got = 1'b1;
			end else if (hdr_b3 == BYTE_FF && hdr_b4 == BYTE_FF) begin
				scan_ph = PH_BODY;
				pay_len = {8'h00, b};
				resp_ok = 1'b0;
				frame_pos = POS_LEN_HI;
			end else begin
				// bad header: replay bytes 3..5 into a fresh search
				h3 = hdr_b3;
				h4 = hdr_b4;
				scan_ph = PH_NONE;
				frame_pos = '0;
				search_start(h3);
				search_start(h4);
				search_start(b);
			end
		end else if (scan_ph == PH_BODY) begin
			final_pos = OFS_FINAL + {1'b0, pay_len};
			if (frame_pos == POS_LEN_HI) begin
				pay_len[15:8] = b;
			end else if (frame_pos == POS_CODE) begin
				resp_ok = (pay_len >= MIN_PAYLOAD) && (b == BYTE_RESP);
			end else if (frame_pos == POS_CMD) begin
				if ({1'b0, b} != ({1'b0, cmd_reg} + 9'd1))
					resp_ok = 1'b0;
			end
			if (frame_pos >= POS_DATA && frame_pos <= OFS_DATA_END + {1'b0, pay_len}
					&& resp_ok) begin
				res.kind = KIND_DATA;
				res.data = b;
				got = 1'b1;
			end
			if (frame_pos >= POS_CMD && frame_pos == final_pos) begin
				if (resp_ok) begin
					res.kind = KIND_END;
					res.data = 8'h00;
					res.last = 1'b1;
					got = 1'b1;
				end
				scan_ph = PH_NONE;
				frame_pos = '0;
				pay_len = '0;
				resp_ok = 1'b0;
			end else begin
				frame_pos = frame_pos + 17'd1;
			end
		end else begin
			search_start(b);
		end
		return got;
	endfunction

	// driver: bytes, register writes, drains and idling changes in queue order
	always @(posedge clk or negedge arst_n) begin : drive_proc
		frame_result_t res;
		logic          nxt_push;
		logic [7:0]    nxt_byte;
		logic          nxt_cfg;
		logic [7:0]    nxt_cfg_data;
		bit            settled;
		if (!arst_n) begin
			push <= 1'b0;
			rx_byte <= 8'h00;
			cfg_valid <= 1'b0;
			cfg_data <= 8'h00;
			quiet_cycles = 0;
		end else begin
			nxt_push = push;
			nxt_byte = rx_byte;
			nxt_cfg = cfg_valid;
			nxt_cfg_data = cfg_data;
			if (push && !full) begin
				if (scan_byte(rx_byte, res))
					awaited_results = {awaited_results, res};
				nxt_push = 1'b0;
				quiet_cycles = 0;
			end
			if (cfg_valid && cfg_ready) begin
				cmd_reg = cfg_data;
				nxt_cfg = 1'b0;
			end
			// quiet once nothing is awaited and the last byte has had time to pass
			if (awaited_results.size() != 0)
				quiet_cycles = 0;
			else if (!(push && !full))
				quiet_cycles++;
			settled = (quiet_cycles >= HOLD_CYCLES);
			if (!nxt_push && !nxt_cfg && link_requests.size() != 0) begin
				case (link_requests[0].kind)
					REQ_BYTE: begin
						if ($urandom_range(0, 99) >= send_idle_pct) begin
							nxt_byte = link_requests[0].value;
							nxt_push = 1'b1;
							void'(link_requests.pop_front());
						end
					end
					REQ_CFG: begin
						if (settled) begin
							nxt_cfg = 1'b1;
							nxt_cfg_data = link_requests[0].value;
							void'(link_requests.pop_front());
						end
					end
					REQ_DRAIN: begin
						if (settled)
							void'(link_requests.pop_front());
					end
					default: begin
						send_idle_pct = link_requests[0].send_idle;
						recv_stall_pct = link_requests[0].recv_stall;
						void'(link_requests.pop_front());
					end
				endcase
			end
			push <= nxt_push;
			rx_byte <= nxt_byte;
			cfg_valid <= nxt_cfg;
			cfg_data <= nxt_cfg_data;
		end
	end

	// monitor: compare each popped result with the oldest awaited one
	always @(posedge clk or negedge arst_n) begin : check_proc
		frame_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: result_kind %0d data_byte %02h last %0d",
						result_kind, data_byte, last);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
						mismatches++;
					end
					if (data_byte !== want.data) begin
						$error("data_byte: expected %02h, got %02h", want.data, data_byte);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						mismatches++;
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		link_request_t r;
		r.kind = REQ_BYTE;
		r.value = b;
		r.send_idle = 0;
		r.recv_stall = 0;
		link_requests = {link_requests, r};
		bytes_queued++;
	endtask

	task automatic queue_cfg(input logic [7:0] v);
		link_request_t r;
		r.kind = REQ_CFG;
		r.value = v;
		r.send_idle = 0;
		r.recv_stall = 0;
		link_requests = {link_requests, r};
		cmd_plan = v;
	endtask

	task automatic queue_drain();
		link_request_t r;
		r.kind = REQ_DRAIN;
		r.value = 8'h00;
		r.send_idle = 0;
		r.recv_stall = 0;
		link_requests = {link_requests, r};
	endtask

	task automatic queue_mode(input int send_idle, input int recv_stall);
		link_request_t r;
		r.kind = REQ_MODE;
		r.value = 8'h00;
		r.send_idle = send_idle;
		r.recv_stall = recv_stall;
		link_requests = {link_requests, r};
	endtask

	// byte biased towards the values that steer the scanner
	function automatic logic [7:0] steer_byte();
		int pick;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			return BYTE_ZERO;
		else if (pick == 1)
			return BYTE_FF;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] cmd_choice();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return 8'h00;
		else if (pick < 30)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic queue_start_code();
		if ($urandom_range(0, 3) == 0)
			queue_byte(BYTE_ZERO);
		queue_byte(BYTE_ZERO);
		queue_byte(BYTE_ZERO);
		queue_byte(BYTE_FF);
	endtask

	// extended frame, optionally retuning the command just before byte 9
	task automatic queue_ext_frame(input logic [15:0] len, input logic [7:0] code,
			input logic [7:0] cmd_byte, input bit retune, input logic [7:0] retune_val);
		int unsigned p;
		queue_start_code();
		queue_byte(BYTE_FF);
		queue_byte(BYTE_FF);
		queue_byte(len[7:0]);
		queue_byte(len[15:8]);
		queue_byte(8'($urandom));
		for (p = 8; p <= 9 + int'(len); p++) begin
			if (p == 9 && retune)
				queue_cfg(retune_val);
			if (p == 8)
				queue_byte(code);
			else if (p == 9)
				queue_byte(cmd_byte);
			else
				queue_byte(8'($urandom));
		end
	endtask

	// random traffic, mostly well-formed frames with random content
	task automatic queue_random_traffic(input int target);
		int         stop_at;
		int         pick;
		int         n;
		logic [15:0] len;
		logic [7:0]  code;
		logic [7:0]  cmd_byte;
		logic [7:0]  nv;
		bit          retune;
		stop_at = bytes_queued + target;
		while (bytes_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 12))
					: 16'($urandom_range(13, 300));
				code = ($urandom_range(0, 99) < 90) ? BYTE_RESP : 8'($urandom);
				retune = ($urandom_range(0, 99) < 4);
				nv = retune ? cmd_choice() : cmd_plan;
				cmd_byte = ($urandom_range(0, 99) < 80) ? nv + 8'd1 : 8'($urandom);
				queue_ext_frame(len, code, cmd_byte, retune, nv);
			end else if (pick < 70) begin
				queue_start_code();
				queue_byte(BYTE_ZERO);
				queue_byte(BYTE_FF);
				queue_byte(BYTE_ZERO);
			end else if (pick < 82) begin
				// broken header
				queue_start_code();
				repeat (3) queue_byte(steer_byte());
			end else if (pick < 90) begin
				// truncated start code
				queue_byte(BYTE_ZERO);
				if ($urandom_range(0, 1) == 1)
					queue_byte(BYTE_ZERO);
				queue_byte(8'($urandom_range(1, 254)));
			end else if (pick < 95) begin
				n = $urandom_range(1, 6);
				repeat (n) queue_byte(8'($urandom));
			end else if (pick < 98) begin
				queue_cfg(cmd_choice());
			end else begin
				queue_drain();
			end
		end
	endtask

	initial begin : run_proc
		int drain_wait;

		// directed: response with extreme data bytes
		queue_ext_frame(16'd4, BYTE_RESP, 8'h01, 1'b0, 8'h00);
		link_requests[link_requests.size() - 4].value = 8'h00;
		link_requests[link_requests.size() - 3].value = 8'hFF;
		// directed: bad header that holds a start code, then an acknowledge tail
		queue_start_code();
		queue_byte(BYTE_ZERO);
		queue_byte(BYTE_ZERO);
		queue_byte(BYTE_FF);
		queue_byte(BYTE_ZERO);
		queue_byte(BYTE_FF);
		queue_byte(BYTE_ZERO);

		// sender idles lightly, receiver heavily
		queue_mode(21, 71);
		queue_cfg(8'h00);
		queue_random_traffic(650);
		queue_drain();

		// roles swapped, command at its top value
		queue_mode(71, 21);
		queue_cfg(8'hFF);
		queue_random_traffic(650);
		queue_drain();

		// no idling, long frame with a two-byte length and a rejected payload
		queue_mode(0, 0);
		queue_cfg(8'($urandom));
		queue_random_traffic(300);
		queue_ext_frame(16'd260, BYTE_RESP, cmd_plan + 8'd2, 1'b0, 8'h00);
		queue_random_traffic(100);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (link_requests.size() != 0 || push || cfg_valid)
			@(posedge clk);
		drain_wait = 0;
		while (awaited_results.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (10) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d expected results never arrived", awaited_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("nfc_response_frame_receiver test passed");
		else
			$display("nfc_response_frame_receiver test failed");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("nfc_response_frame_receiver test failed");
		$finish;
	end

endmodule
